// ===== rtl/core/bmg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_pkg
// Shared constants and types for the Box-Muller Gaussian sample pipeline.
// ----------------------------------------------------------------------------
package bmg_pkg;

  localparam int LOG_FRAC    = 24;
  localparam int NUM_TERMS   = 5;
  localparam int RECIP_SHIFT = 36;
  localparam int RECIP_W     = 36;

  localparam logic [32:0] LN2_X2     = 33'd5954088944;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  localparam int unsigned TERM_DIV [NUM_TERMS] = '{110, 72, 42, 20, 6};

  typedef enum logic [0:0] {
    REG_MEAN      = 1'b0,
    REG_DEVIATION = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [30:0] theta;
    logic [31:0] t;
    logic [30:0] h;
  } sin_bus_t;

endpackage
`default_nettype wire

// ===== rtl/core/bmg_norm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_norm_cell
// One step of the leading-zero normalizer: shift by a fixed span when clear.
// ----------------------------------------------------------------------------
module bmg_norm_cell #(
  parameter int W     = 32,
  parameter int K_W   = 5,
  parameter int SHIFT = 16
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   a_i,
  input  logic [K_W-1:0] k_i,
  output logic [W-1:0]   a_o,
  output logic [K_W-1:0] k_o
);
  logic [W-1:0]   a_r;
  logic [K_W-1:0] k_r;
  logic           clear;

  assign clear = (a_i[W-1 -: SHIFT] == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      if (clear) begin
        a_r <= a_i << SHIFT;
        k_r <= k_i + K_W'(SHIFT);
      end else begin
        a_r <= a_i;
        k_r <= k_i;
      end
    end
  end

  assign a_o = a_r;
  assign k_o = k_r;
endmodule
`default_nettype wire

// ===== rtl/core/bmg_log_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_log_cell
// One bit of log2 by repeated squaring of a Q1.30 mantissa.
// ----------------------------------------------------------------------------
module bmg_log_cell #(
  parameter int K_W = 5
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [30:0]                  y_i,
  input  logic [bmg_pkg::LOG_FRAC-1:0] frac_i,
  input  logic [K_W-1:0]               k_i,
  output logic [30:0]                  y_o,
  output logic [bmg_pkg::LOG_FRAC-1:0] frac_o,
  output logic [K_W-1:0]               k_o
);
  import bmg_pkg::*;

  logic [61:0]         sq;
  logic [31:0]         ys;
  logic [30:0]         y_r;
  logic [LOG_FRAC-1:0] frac_r;
  logic [K_W-1:0]      k_r;

  assign sq = 62'(y_i) * 62'(y_i);
  assign ys = sq[61:30];

  always_ff @(posedge clk) begin
    if (en) begin
      if (ys[31]) begin
        y_r    <= ys[31:1];
        frac_r <= {frac_i[LOG_FRAC-2:0], 1'b1};
      end else begin
        y_r    <= ys[30:0];
        frac_r <= {frac_i[LOG_FRAC-2:0], 1'b0};
      end
      k_r <= k_i;
    end
  end

  assign y_o    = y_r;
  assign frac_o = frac_r;
  assign k_o    = k_r;
endmodule
`default_nettype wire

// ===== rtl/core/bmg_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_sqrt_cell
// One root bit of a digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module bmg_sqrt_cell #(
  parameter int RAD_W  = 56,
  parameter int ROOT_W = 28
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [ROOT_W+1:0] rem_i,
  input  logic [ROOT_W-1:0] root_i,
  output logic [RAD_W-1:0]  rad_o,
  output logic [ROOT_W+1:0] rem_o,
  output logic [ROOT_W-1:0] root_o
);
  logic [ROOT_W+1:0] rem_n;
  logic [ROOT_W+1:0] trial;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;

  assign rem_n = {rem_i[ROOT_W-1:0], rad_i[RAD_W-1 -: 2]};
  assign trial = {root_i, 2'b01};

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= {rad_i[RAD_W-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_r  <= rem_n - trial;
        root_r <= {root_i[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_n;
        root_r <= {root_i[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
endmodule
`default_nettype wire

// ===== rtl/core/bmg_sin_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_sin_cell
// One Horner term of the sine series: h = 1 - ((t*h)>>30)/DIVISOR, 3 stages.
// ----------------------------------------------------------------------------
module bmg_sin_cell #(
  parameter int unsigned DIVISOR = 6
) (
  input  logic              clk,
  input  logic              en,
  input  bmg_pkg::sin_bus_t bus_i,
  output bmg_pkg::sin_bus_t bus_o
);
  import bmg_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / DIVISOR);
  localparam logic [31:0]        DIV_C = 32'(DIVISOR);

  logic [62:0]          prod_nxt;
  logic [62:0]          prod_r;
  sin_bus_t             b1_r;
  logic [31:0]          v;
  logic [RECIP_W+31:0]  mulr_nxt;
  logic [RECIP_W+31:0]  mulr_r;
  logic [31:0]          v_r;
  sin_bus_t             b2_r;
  logic [31:0]          q0;
  logic [31:0]          rem;
  logic [31:0]          q;
  sin_bus_t             b3_r;

  assign prod_nxt = 63'(bus_i.t) * 63'(bus_i.h);
  assign v        = prod_r[61:30];
  assign mulr_nxt = (RECIP_W+32)'(v) * (RECIP_W+32)'(RECIP);
  assign q0       = mulr_r[RECIP_SHIFT +: 32];
  assign rem      = v_r - 32'(q0 * DIV_C);
  assign q        = (rem >= DIV_C) ? q0 + 32'd1 : q0;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r     <= prod_nxt;
      b1_r       <= bus_i;
      mulr_r     <= mulr_nxt;
      v_r        <= v;
      b2_r       <= b1_r;
      b3_r.theta <= b2_r.theta;
      b3_r.t     <= b2_r.t;
      b3_r.h     <= ONE_Q30 - q[30:0];
    end
  end

  assign bus_o = b3_r;
endmodule
`default_nettype wire

// ===== rtl/core/box_muller_gaussian.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_muller_gaussian
// Box-Muller normal sample generator: sqrt(-ln a^2) * sin(2 pi b) * dev + mean.
//
// Input channel in_*: one item carries two uniform fractions (a nonzero).
// Output channel out_*: one signed Q16.16 sample per item, tuser flags clipping.
// cfg_*: write mean (index 0) and deviation (index 1) while the block is idle.
// Throughput: one item per cycle while no item waits in the skid register.
// Path from accept to out_tvalid: normalizer, 24 log2 squaring cells, the
// -ln(a^2) register, one square root cell per root bit (ROOT_W is the root
// width of the square root chain), then the scale, magnitude and result
// registers and the output register; the sine chain runs beside them and
// is delayed to line up.
// Reset clears all valid bits, sets mean to 0 and deviation to 1.0.
// When the receiver stalls, a skid register takes the item leaving the
// pipeline and in_tready drops until the skid register drains.
// ----------------------------------------------------------------------------
module box_muller_gaussian #(
  parameter int UNIFORM_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // uniform_a, uniform_b
  input  logic [((2*UNIFORM_BITS+7)/8)*8-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // sample
  output logic [31:0]                             out_tdata,
  // saturated
  output logic                                    out_tuser,
  input  logic                                    cfg_we,
  input  logic                                    cfg_index,
  input  logic [31:0]                             cfg_wdata
);
  import bmg_pkg::*;

  localparam int K_W    = $clog2(UNIFORM_BITS);
  localparam int NORM_N = K_W;
  localparam int L_W    = K_W + 1 + LOG_FRAC;
  localparam int PROD_W = L_W + 34;
  localparam int R2_W   = L_W + 2;
  localparam int SQ_W0  = R2_W + LOG_FRAC;
  localparam int RAD_W  = SQ_W0 + (SQ_W0 % 2);
  localparam int ROOT_W = RAD_W / 2;
  localparam int LAT_A  = NORM_N + LOG_FRAC + 1 + ROOT_W;
  localparam int LAT_B  = 3 + 3 * NUM_TERMS;
  localparam int S_DLY  = LAT_A - LAT_B;
  localparam int G_W    = ROOT_W + 1;
  localparam int M_W    = G_W + 1;
  localparam int SUM_W  = ((M_W > 32) ? M_W : 32) + 2;
  localparam int PIPE_N = LAT_A + 3;

  logic                    adv;
  logic                    skid_valid_r;
  logic [UNIFORM_BITS-1:0] ua;
  logic [UNIFORM_BITS-1:0] ub;
  logic [UNIFORM_BITS-1:0] a_fix;

  logic [31:0] mean_r;
  logic [23:0] dev_r;

  logic [PIPE_N-1:0] vld_r;
  logic [LAT_A+1:0]  neg_r;

  assign adv   = ~skid_valid_r;
  assign ua    = in_tdata[UNIFORM_BITS-1:0];
  assign ub    = in_tdata[2*UNIFORM_BITS-1:UNIFORM_BITS];
  assign a_fix = (ua == '0) ? UNIFORM_BITS'(1) : ua;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      dev_r  <= 24'd65536;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MEAN:      mean_r <= cfg_wdata;
        REG_DEVIATION: dev_r  <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // normalizer chain
  logic [UNIFORM_BITS-1:0] norm_a [NORM_N+1];
  logic [K_W-1:0]          norm_k [NORM_N+1];

  assign norm_a[0] = a_fix;
  assign norm_k[0] = '0;

  for (genvar i = 0; i < NORM_N; i++) begin : g_norm
    bmg_norm_cell #(
      .W     (UNIFORM_BITS),
      .K_W   (K_W),
      .SHIFT (1 << (NORM_N - 1 - i))
    ) u_norm (
      .clk (clk),
      .en  (adv),
      .a_i (norm_a[i]),
      .k_i (norm_k[i]),
      .a_o (norm_a[i+1]),
      .k_o (norm_k[i+1])
    );
  end

  // log2 chain
  logic [30:0]         log_y [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] log_f [LOG_FRAC+1];
  logic [K_W-1:0]      log_k [LOG_FRAC+1];

  if (UNIFORM_BITS >= 31) begin : g_y_top
    assign log_y[0] = norm_a[NORM_N][UNIFORM_BITS-1 -: 31];
  end else begin : g_y_pad
    assign log_y[0] = {norm_a[NORM_N], {(31-UNIFORM_BITS){1'b0}}};
  end
  assign log_f[0] = '0;
  assign log_k[0] = norm_k[NORM_N];

  for (genvar i = 0; i < LOG_FRAC; i++) begin : g_log
    bmg_log_cell #(
      .K_W (K_W)
    ) u_log (
      .clk    (clk),
      .en     (adv),
      .y_i    (log_y[i]),
      .frac_i (log_f[i]),
      .k_i    (log_k[i]),
      .y_o    (log_y[i+1]),
      .frac_o (log_f[i+1]),
      .k_o    (log_k[i+1])
    );
  end

  // -ln(a^2) in Q.24
  logic [L_W-1:0]    l_val;
  logic [PROD_W-1:0] r2_prod;
  logic [R2_W-1:0]   r2_r;

  assign l_val   = {(K_W+1)'(log_k[LOG_FRAC]) + (K_W+1)'(1), LOG_FRAC'(0)}
                 - L_W'(log_f[LOG_FRAC]);
  assign r2_prod = PROD_W'(l_val) * PROD_W'(LN2_X2) + (PROD_W'(1) << 31);

  always_ff @(posedge clk) begin
    if (adv) r2_r <= r2_prod[PROD_W-1:32];
  end

  // square root chain
  logic [RAD_W-1:0]  sq_rad  [ROOT_W+1];
  logic [ROOT_W+1:0] sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] sq_root [ROOT_W+1];

  assign sq_rad[0]  = RAD_W'({r2_r, LOG_FRAC'(0)});
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    bmg_sqrt_cell #(
      .RAD_W  (RAD_W),
      .ROOT_W (ROOT_W)
    ) u_sqrt (
      .clk    (clk),
      .en     (adv),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1])
    );
  end

  // phase and sine chain
  logic [31:0] phase;
  logic [30:0] x;
  logic [63:0] theta_prod;
  logic [30:0] theta_r;
  logic [61:0] t_sq;
  sin_bus_t    sin_bus [NUM_TERMS+1];
  sin_bus_t    bus0_r;
  logic [61:0] s_prod;
  logic [30:0] s_r;
  logic [30:0] s_dly_r [S_DLY];

  if (UNIFORM_BITS >= 32) begin : g_p_top
    assign phase = ub[UNIFORM_BITS-1 -: 32];
  end else begin : g_p_pad
    assign phase = {ub, {(32-UNIFORM_BITS){1'b0}}};
  end

  assign x          = phase[30] ? ONE_Q30 - {1'b0, phase[29:0]} : {1'b0, phase[29:0]};
  assign theta_prod = 64'(x) * 64'(TWO_PI_Q30);
  assign t_sq       = 62'(theta_r) * 62'(theta_r);
  assign sin_bus[0] = bus0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      theta_r      <= theta_prod[62:32];
      bus0_r.theta <= theta_r;
      bus0_r.t     <= t_sq[61:30];
      bus0_r.h     <= ONE_Q30;
    end
  end

  for (genvar i = 0; i < NUM_TERMS; i++) begin : g_sin
    bmg_sin_cell #(
      .DIVISOR (TERM_DIV[i])
    ) u_sin (
      .clk   (clk),
      .en    (adv),
      .bus_i (sin_bus[i]),
      .bus_o (sin_bus[i+1])
    );
  end

  assign s_prod = 62'(sin_bus[NUM_TERMS].theta) * 62'(sin_bus[NUM_TERMS].h);

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r        <= s_prod[60:30];
      s_dly_r[0] <= s_r;
      for (int i = 1; i < S_DLY; i++) s_dly_r[i] <= s_dly_r[i-1];
    end
  end

  // scale, offset and saturate
  logic [ROOT_W+30:0]      g_prod;
  logic [G_W-1:0]          g_r;
  logic [G_W+24:0]         m_prod;
  logic [M_W-1:0]          mag_r;
  logic [SUM_W-1:0]        mag_ext;
  logic [SUM_W-1:0]        total;
  logic                    over;
  logic [31:0]             res_sample_r;
  logic                    res_sat_r;

  assign g_prod  = (ROOT_W+31)'(sq_root[ROOT_W]) * (ROOT_W+31)'(s_dly_r[S_DLY-1]);
  assign m_prod  = (G_W+25)'(g_r) * (G_W+25)'(dev_r) + ((G_W+25)'(1) << 23);
  assign mag_ext = SUM_W'(mag_r);
  assign total   = (neg_r[LAT_A+1] ? (SUM_W'(0) - mag_ext) : mag_ext)
                 + {{(SUM_W-32){mean_r[31]}}, mean_r};
  assign over    = (total[SUM_W-1:31] != '0) && (total[SUM_W-1:31] != '1);

  always_ff @(posedge clk) begin
    if (adv) begin
      g_r   <= g_prod[ROOT_W+30:30];
      mag_r <= m_prod[G_W+24:24];
      if (over) begin
        res_sample_r <= total[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        res_sat_r    <= 1'b1;
      end else begin
        res_sample_r <= total[31:0];
        res_sat_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) neg_r <= {neg_r[LAT_A:0], phase[31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_N-2:0], in_tvalid};
    end
  end

  // output register and skid
  logic        out_valid_r;
  logic [31:0] out_sample_r;
  logic        out_sat_r;
  logic [31:0] skid_sample_r;
  logic        skid_sat_r;
  logic        pipe_out;
  logic        out_free;

  assign pipe_out = vld_r[PIPE_N-1] & adv;
  assign out_free = out_tready | ~out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r | pipe_out;
      skid_valid_r <= 1'b0;
    end else if (pipe_out) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_sample_r <= skid_sample_r;
        out_sat_r    <= skid_sat_r;
      end else begin
        out_sample_r <= res_sample_r;
        out_sat_r    <= res_sat_r;
      end
    end else if (pipe_out) begin
      skid_sample_r <= res_sample_r;
      skid_sat_r    <= res_sat_r;
    end
  end

  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = out_sat_r;
endmodule
`default_nettype wire
